[sv/linear_probe_hash_table_macros.svh]
// ----------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Concurrent assertion forms used by the probe engine RTL.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LPHT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LPHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared widths, codes and record types for the hash table blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

    localparam int CAPACITY_DEF     = 256;
    localparam int CODE_BYTES_DEF   = 8;
    localparam int TABLE_SIZE_RESET = 179;

    localparam int ACTION_W = 2;
    localparam int CODE_W   = 64;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;
    localparam int TSIZE_W  = 9;
    // byte sum of eight code bytes: at most 8 * 255
    localparam int SUM_W    = 11;
    localparam int Q_DEPTH  = 2;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CODE_W-1:0]   code;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   code;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

[sv/linear_probe_hash_table.sv]
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressed code/handle table with linear probing over table_size slots, clamped to 1..CAPACITY.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata (low bit up)             tuser
//  s_        in   key_code[63:0], record_handle  action[1:0]
//  m_        out  slot_index[7:0], found_handle  status[2:0]
//  cfg_wr_   in   table_size[8:0]                -
//
//  The front end hashes one request at a time and takes no new one until it
//  has pushed the last, running one restoring step of the home-slot modulo
//  per cycle; the probe engine then reads one slot per cycle. Front end and
//  probe engine overlap through a two-entry queue.
//  After reset a clearing pass writes every slot empty, and no request leaves
//  the queue until it ends. A stalled result holds only the probe engine; the
//  front end keeps taking requests until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table #(
    parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
    parameter int CODE_BYTES = lpht_pkg::CODE_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // table_size[8:0]
    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // key_code[63:0], record_handle[79:64]
    input  wire logic [79:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // slot_index[7:0], found_handle[23:8]
    output logic [23:0]      m_tdata,
    // status[2:0]
    output logic [2:0]       m_tuser
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SZ_W  = (CNT_W > lpht_pkg::TSIZE_W) ? CNT_W : lpht_pkg::TSIZE_W;
    localparam int QW    = $bits(lpht_pkg::req_t) + IDX_W;

    logic [lpht_pkg::TSIZE_W-1:0] table_size_reg;
    logic [SZ_W-1:0]              size_wide, size_clamped;
    logic [CNT_W-1:0]             eff_size;

    lpht_pkg::req_t     in_req;
    lpht_pkg::q_stat_t  q_stat;
    logic               q_push, q_pop;
    logic [QW-1:0]      q_in, q_out;

    logic [lpht_pkg::STATUS_W-1:0] out_status;
    logic [lpht_pkg::SLOT_W-1:0]   out_slot;
    logic [lpht_pkg::HANDLE_W-1:0] out_handle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= lpht_pkg::TSIZE_W'(lpht_pkg::TABLE_SIZE_RESET);
        end else if (cfg_wr_en) begin
            table_size_reg <= cfg_wr_data;
        end
    end

    // zero acts as one slot, anything above capacity as capacity
    assign size_wide    = SZ_W'(table_size_reg);
    assign size_clamped = (size_wide == '0) ? SZ_W'(1)
                        : (size_wide > SZ_W'(CAPACITY)) ? SZ_W'(CAPACITY) : size_wide;
    assign eff_size     = CNT_W'(size_clamped);

    assign in_req.action = s_tuser;
    assign in_req.code   = s_tdata[63:0];
    assign in_req.handle = s_tdata[79:64];

    lpht_front #(
        .CAPACITY   (CAPACITY),
        .CODE_BYTES (CODE_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .eff_size (eff_size),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (in_req),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_stat   (q_stat)
    );

    lpht_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    lpht_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .eff_size   (eff_size),
        .q_data     (q_out),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_slot   (out_slot),
        .out_handle (out_handle)
    );

    assign m_tdata = {out_handle, out_slot};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

[sv/lpht_fifo.sv]
// ----------------------------------------------------------------------------
// Request queue
// Short register queue between the hashing front end and the probe engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        pop_data,
    output lpht_pkg::q_stat_t       stat
);

    localparam int PTR_W = $clog2(lpht_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(lpht_pkg::Q_DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [lpht_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(lpht_pkg::Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lpht_pkg::Q_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lpht_pkg::Q_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[sv/lpht_front.sv]
// ----------------------------------------------------------------------------
// Hash front end
// Accepts requests, masks the code and reduces its byte sum to a home slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_front #(
    parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
    parameter int CODE_BYTES = lpht_pkg::CODE_BYTES_DEF,
    localparam int IDX_W     = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [CNT_W-1:0]              eff_size,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire lpht_pkg::req_t                in_req,
    output logic                               q_push,
    output logic [$bits(lpht_pkg::req_t)+IDX_W-1:0] q_data,
    input  wire lpht_pkg::q_stat_t             q_stat
);

    localparam int DIV_W  = lpht_pkg::SUM_W + CNT_W;
    localparam int STEP_W = $clog2(lpht_pkg::SUM_W);

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_DIV  = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    logic [1:0]                 state_reg, state_next;
    lpht_pkg::req_t             req_reg, req_next;
    logic [lpht_pkg::SUM_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]          step_reg, step_next;

    logic [lpht_pkg::CODE_W-1:0] masked_code;
    logic [lpht_pkg::SUM_W-1:0]  byte_sum;
    logic [DIV_W-1:0]            shifted;

    always_comb begin
        masked_code = '0;
        byte_sum    = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < CODE_BYTES) begin
                masked_code[8*b +: 8] = in_req.code[8*b +: 8];
            end
            byte_sum = byte_sum + lpht_pkg::SUM_W'(masked_code[8*b +: 8]);
        end
    end

    assign shifted  = DIV_W'(eff_size) << step_reg;
    assign in_ready = (state_reg == FS_IDLE);
    assign q_push   = (state_reg == FS_PUSH);
    assign q_data   = {req_reg, IDX_W'(rem_reg)};

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        case (state_reg)
            FS_IDLE: begin
                if (in_valid) begin
                    req_next        = in_req;
                    req_next.code   = masked_code;
                    rem_next        = byte_sum;
                    step_next       = STEP_W'(lpht_pkg::SUM_W - 1);
                    state_next      = FS_DIV;
                end
            end
            FS_DIV: begin
                // one restoring step: subtract the shifted divisor where it fits
                if (DIV_W'(rem_reg) >= shifted) begin
                    rem_next = rem_reg - lpht_pkg::SUM_W'(shifted);
                end
                if (step_reg == '0) begin
                    state_next = FS_PUSH;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            FS_PUSH: begin
                if (!q_stat.full) begin
                    state_next = FS_IDLE;
                end
            end
            default: begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

endmodule

`default_nettype wire

[sv/lpht_back.sv]
// ----------------------------------------------------------------------------
// Probe engine
// Walks the slot memory from the home slot and carries out each request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_probe_hash_table_macros.svh"

module lpht_back #(
    parameter int CAPACITY = lpht_pkg::CAPACITY_DEF,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [CNT_W-1:0]                   eff_size,
    input  wire logic [$bits(lpht_pkg::req_t)+IDX_W-1:0] q_data,
    input  wire lpht_pkg::q_stat_t                  q_stat,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [lpht_pkg::STATUS_W-1:0]           out_status,
    output logic [lpht_pkg::SLOT_W-1:0]             out_slot,
    output logic [lpht_pkg::HANDLE_W-1:0]           out_handle
);

    localparam logic [1:0] BS_CLEAR = 2'd0;
    localparam logic [1:0] BS_IDLE  = 2'd1;
    localparam logic [1:0] BS_WALK  = 2'd2;
    localparam logic [1:0] BS_HOLD  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [IDX_W-1:0]             clr_addr_reg, clr_addr_next;
    lpht_pkg::req_t               cur_reg, cur_next;
    logic [IDX_W-1:0]             addr_reg, addr_next;
    logic [CNT_W-1:0]             iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0]             chk_cnt_reg, chk_cnt_next;
    logic                         chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]             chk_addr_reg, chk_addr_next;
    logic [lpht_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]             res_slot_reg, res_slot_next;
    logic [lpht_pkg::HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                         out_valid_reg, out_valid_next;
    logic [lpht_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [lpht_pkg::SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [lpht_pkg::HANDLE_W-1:0] out_handle_reg, out_handle_next;

    lpht_pkg::entry_t             mem [CAPACITY];
    lpht_pkg::entry_t             rd_data_reg;
    lpht_pkg::entry_t             mem_wd;
    logic [IDX_W-1:0]             mem_wa;
    logic                         mem_we;

    lpht_pkg::req_t               q_req;
    logic [IDX_W-1:0]             q_home;
    logic                         is_insert;
    logic                         hit, last, verdict, issue;
    logic [CNT_W-1:0]             addr_inc;
    logic [IDX_W+lpht_pkg::SLOT_W-1:0] slot_ext;

    assign q_req     = q_data[$bits(lpht_pkg::req_t)+IDX_W-1:IDX_W];
    assign q_home    = q_data[IDX_W-1:0];
    assign is_insert = (cur_reg.action == lpht_pkg::ACT_INSERT);

    assign hit = chk_vld_reg && (is_insert ? !rd_data_reg.valid
                                           : (rd_data_reg.valid &&
                                              rd_data_reg.code == cur_reg.code));
    assign last     = chk_vld_reg && (chk_cnt_reg + 1'b1 == eff_size);
    assign verdict  = (state_reg == BS_WALK) && (hit || last);
    assign issue    = (state_reg == BS_WALK) && !verdict && (iss_cnt_reg < eff_size);
    assign addr_inc = CNT_W'(addr_reg) + 1'b1;
    assign slot_ext = {{lpht_pkg::SLOT_W{1'b0}}, res_slot_reg};

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_handle = out_handle_reg;

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cur_next        = cur_reg;
        addr_next       = addr_reg;
        iss_cnt_next    = iss_cnt_reg;
        chk_cnt_next    = chk_cnt_reg;
        chk_vld_next    = issue;
        chk_addr_next   = addr_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_handle_next = res_handle_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_handle_next = out_handle_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = chk_addr_reg;
        mem_wd          = rd_data_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BS_CLEAR: begin
                mem_we    = 1'b1;
                mem_wa    = clr_addr_reg;
                mem_wd    = '0;
                if (clr_addr_reg == IDX_W'(CAPACITY - 1)) begin
                    state_next = BS_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            BS_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop        = 1'b1;
                    cur_next     = q_req;
                    addr_next    = q_home;
                    iss_cnt_next = '0;
                    chk_cnt_next = '0;
                    if (q_req.action inside {lpht_pkg::ACT_INSERT, lpht_pkg::ACT_SEARCH,
                                             lpht_pkg::ACT_REMOVE}) begin
                        state_next = BS_WALK;
                    end else begin
                        res_status_next = lpht_pkg::ST_NOT_FOUND;
                        res_slot_next   = '0;
                        res_handle_next = '0;
                        state_next      = BS_HOLD;
                    end
                end
            end
            BS_WALK: begin
                if (issue) begin
                    addr_next    = (addr_inc == eff_size) ? '0 : IDX_W'(addr_inc);
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                end
                if (chk_vld_reg) begin
                    chk_cnt_next = chk_cnt_reg + 1'b1;
                end
                if (verdict) begin
                    state_next = BS_HOLD;
                    if (hit) begin
                        res_slot_next = chk_addr_reg;
                        case (cur_reg.action)
                            lpht_pkg::ACT_INSERT: begin
                                mem_we          = 1'b1;
                                mem_wd.valid    = 1'b1;
                                mem_wd.code     = cur_reg.code;
                                mem_wd.handle   = cur_reg.handle;
                                res_status_next = lpht_pkg::ST_INSERTED;
                                res_handle_next = '0;
                            end
                            lpht_pkg::ACT_REMOVE: begin
                                // drop the valid bit, keep the stored payload
                                mem_we          = 1'b1;
                                mem_wd.valid    = 1'b0;
                                res_status_next = lpht_pkg::ST_REMOVED;
                                res_handle_next = rd_data_reg.handle;
                            end
                            default: begin
                                res_status_next = lpht_pkg::ST_FOUND;
                                res_handle_next = rd_data_reg.handle;
                            end
                        endcase
                    end else begin
                        res_status_next = is_insert ? lpht_pkg::ST_FULL
                                                    : lpht_pkg::ST_NOT_FOUND;
                        res_slot_next   = '0;
                        res_handle_next = '0;
                    end
                end
            end
            BS_HOLD: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = slot_ext[lpht_pkg::SLOT_W-1:0];
                    out_handle_next = res_handle_reg;
                    state_next      = BS_IDLE;
                end
            end
            default: begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BS_CLEAR;
            clr_addr_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        addr_reg       <= addr_next;
        iss_cnt_reg    <= iss_cnt_next;
        chk_cnt_reg    <= chk_cnt_next;
        chk_addr_reg   <= chk_addr_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_handle_reg <= res_handle_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_handle_reg <= out_handle_next;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (issue) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    `LPHT_ASSERT_IMPL(a_issue_bound, aclk, aresetn, state_reg == BS_WALK, iss_cnt_reg <= eff_size, "probe issue count passed table size")
    `LPHT_ASSERT_IMPL(a_check_in_range, aclk, aresetn, chk_vld_reg && state_reg == BS_WALK, CNT_W'(chk_addr_reg) < eff_size, "probed slot outside table")
    `LPHT_ASSERT_NEXT(a_verdict_hold, aclk, aresetn, verdict, state_reg == BS_HOLD && !chk_vld_reg, "walk did not stop after verdict")
    `LPHT_ASSERT_IMPL(a_no_pop_busy, aclk, aresetn, q_pop, !q_stat.empty && state_reg == BS_IDLE, "queue popped while engine busy")

endmodule

`default_nettype wire

[sim/linear_probe_hash_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives insert, search and remove requests through the stream ports with
// random gaps on both sides and checks every reply against a slot-level model
// of the table or, in directed rows, a typed-in reply. A directed table covers
// wrap-around, duplicates, removal holes, a full table and out-of-range sizes;
// random phases follow, each at a different table size.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table_test;

    import lpht_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
    localparam bit CFG = 1'b1;
    localparam bit REQ = 1'b0;
    localparam bit TYPED = 1'b1;
    localparam bit PREDICTED = 1'b0;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 78;
    localparam int HOLD_PHASE      = 3;
    localparam int HOLD_CYCLES     = 200;
    localparam int SETTLE_CYCLES   = 16;
    // longest walk plus the front end, with margin
    localparam int TAIL_CYCLES     = 300;
    localparam int unsigned PHASE_SIZES [NUM_PHASES] =
        '{5, 256, 1, 37, 511, 0, 2, 128, 179};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] found;
    } reply_t;

    typedef struct {
        bit                  cfg_row;
        logic [TSIZE_W-1:0]  size;
        logic [ACTION_W-1:0] action;
        logic [CODE_W-1:0]   code;
        logic [HANDLE_W-1:0] handle;
        bit                  typed;
        reply_t              want;
    } step_t;

    // Expected replies are typed in only where they are plain to see.
    step_t directed_steps [23] = '{
        '{REQ, 9'd0, ACT_SEARCH, 64'h0, 16'hBEEF, TYPED, '{ST_NOT_FOUND, 8'd0, 16'h0}},
        '{REQ, 9'd0, ACT_INSERT, 64'h0, 16'hFFFF, TYPED, '{ST_INSERTED, 8'd0, 16'h0}},
        '{REQ, 9'd0, ACT_SEARCH, 64'h0, 16'h0, TYPED, '{ST_FOUND, 8'd0, 16'hFFFF}},
        '{REQ, 9'd0, ACT_INSERT, '1, 16'h1234, TYPED, '{ST_INSERTED, 8'd71, 16'h0}},
        '{REQ, 9'd0, ACT_SEARCH, '1, 16'h0, TYPED, '{ST_FOUND, 8'd71, 16'h1234}},
        '{REQ, 9'd0, ACT_INSERT, 64'h0, 16'h0001, TYPED, '{ST_INSERTED, 8'd1, 16'h0}},
        '{REQ, 9'd0, ACT_REMOVE, 64'h0, 16'h0, TYPED, '{ST_REMOVED, 8'd0, 16'hFFFF}},
        '{REQ, 9'd0, ACT_SEARCH, 64'h0, 16'h0, TYPED, '{ST_FOUND, 8'd1, 16'h0001}},
        '{REQ, 9'd0, ACT_UNKNOWN, 64'h0, 16'h5A5A, TYPED, '{ST_NOT_FOUND, 8'd0, 16'h0}},
        '{REQ, 9'd0, ACT_REMOVE, 64'h0, 16'h0, TYPED, '{ST_REMOVED, 8'd1, 16'h0001}},
        '{REQ, 9'd0, ACT_REMOVE, 64'h0, 16'h0, TYPED, '{ST_NOT_FOUND, 8'd0, 16'h0}},
        '{REQ, 9'd0, ACT_INSERT, 64'hB2, 16'hAAAA, PREDICTED, '{ST_INSERTED, 8'd0, 16'h0}},
        // home slot taken: wraps to the start of the table
        '{REQ, 9'd0, ACT_INSERT, 64'hB2, 16'h5555, PREDICTED, '{ST_INSERTED, 8'd0, 16'h0}},
        '{REQ, 9'd0, ACT_SEARCH, 64'hB2, 16'h0, PREDICTED, '{ST_INSERTED, 8'd0, 16'h0}},
        '{CFG, 9'd1, ACT_INSERT, 64'h0, 16'h0, PREDICTED, '{ST_INSERTED, 8'd0, 16'h0}},
        '{REQ, 9'd0, ACT_INSERT, 64'hB2, 16'h0, TYPED, '{ST_FULL, 8'd0, 16'h0}},
        '{REQ, 9'd0, ACT_SEARCH, 64'hB2, 16'h0, PREDICTED, '{ST_INSERTED, 8'd0, 16'h0}},
        '{CFG, 9'd0, ACT_INSERT, 64'h0, 16'h0, PREDICTED, '{ST_INSERTED, 8'd0, 16'h0}},
        '{REQ, 9'd0, ACT_REMOVE, 64'hB2, 16'h0, PREDICTED, '{ST_INSERTED, 8'd0, 16'h0}},
        '{REQ, 9'd0, ACT_INSERT, 64'h0102030405060708, 16'h0F0F, PREDICTED,
          '{ST_INSERTED, 8'd0, 16'h0}},
        '{CFG, 9'd511, ACT_INSERT, 64'h0, 16'h0, PREDICTED, '{ST_INSERTED, 8'd0, 16'h0}},
        // walk passes empty slots and wraps to find the entry
        '{REQ, 9'd0, ACT_SEARCH, 64'h0102030405060708, 16'h0, PREDICTED,
          '{ST_INSERTED, 8'd0, 16'h0}},
        '{REQ, 9'd0, ACT_SEARCH, '1, 16'h0, PREDICTED, '{ST_INSERTED, 8'd0, 16'h0}}
    };

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [TSIZE_W-1:0]  cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [79:0]         s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;
    logic [2:0]          m_tuser;

    // table model
    bit                  held_valid  [CAPACITY_DEF];
    logic [CODE_W-1:0]   held_code   [CAPACITY_DEF];
    logic [HANDLE_W-1:0] held_handle [CAPACITY_DEF];
    logic [TSIZE_W-1:0]  table_size_q = 9'(TABLE_SIZE_RESET);

    reply_t              expected_replies [$];
    logic [CODE_W-1:0]   live_codes [$];
    int                  mismatch_count = 0;
    bit                  sender_burst = 1'b0;
    bit                  ready_burst = 1'b0;
    bit                  hold_off_req = 1'b0;

    linear_probe_hash_table u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #25_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic reply_t predict_reply(input logic [ACTION_W-1:0] action,
                                             input logic [CODE_W-1:0] code,
                                             input logic [HANDLE_W-1:0] handle);
        reply_t      r;
        int unsigned span;
        int unsigned pos;
        int unsigned sum;
        r = '{ST_NOT_FOUND, 8'd0, 16'h0};
        span = (table_size_q == 0) ? 1 :
               (table_size_q > CAPACITY_DEF) ? CAPACITY_DEF : table_size_q;
        sum = 0;
        for (int b = 0; b < 8; b++)
            sum += code[8*b +: 8];
        pos = sum % span;
        if (action == ACT_INSERT) begin
            r.status = ST_FULL;
            for (int n = 0; n < span; n++) begin
                if (!held_valid[pos]) begin
                    held_valid[pos]  = 1'b1;
                    held_code[pos]   = code;
                    held_handle[pos] = handle;
                    r.status = ST_INSERTED;
                    r.slot   = 8'(pos);
                    break;
                end
                pos = (pos + 1 == span) ? 0 : pos + 1;
            end
        end else if (action == ACT_SEARCH || action == ACT_REMOVE) begin
            // empty slots do not end the walk
            for (int n = 0; n < span; n++) begin
                if (held_valid[pos] && held_code[pos] == code) begin
                    r.slot  = 8'(pos);
                    r.found = held_handle[pos];
                    if (action == ACT_SEARCH) begin
                        r.status = ST_FOUND;
                    end else begin
                        held_valid[pos] = 1'b0;
                        r.status = ST_REMOVED;
                    end
                    break;
                end
                pos = (pos + 1 == span) ? 0 : pos + 1;
            end
        end
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6 && live_codes.size() > 0)
            return live_codes[$urandom_range(0, live_codes.size() - 1)];
        // small values shifted across bytes share byte sums: dense collisions
        if (r < 8)
            return 64'($urandom_range(0, 15)) << (8 * $urandom_range(0, 7));
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h",
                 $realtime, what, got, want);
    endtask

    task automatic send_request(input logic [ACTION_W-1:0] action,
                                input logic [CODE_W-1:0] code,
                                input logic [HANDLE_W-1:0] handle,
                                input bit typed, input reply_t want);
        int     gap;
        reply_t predicted;
        gap = sender_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {handle, code};
        s_tuser  <= action;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_reply(action, code, handle);
        expected_replies = {expected_replies, (typed ? want : predicted)};
    endtask

    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_table_size(input logic [TSIZE_W-1:0] size);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        table_size_q = size;
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : result_sink
        int     stall;
        int     taken;
        reply_t want;
        taken = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            stall = ready_burst ? 0 : $urandom_range(0, 13);
            if (hold_off_req) begin
                stall += HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (expected_replies.size() == 0) begin
                report_mismatch("reply with no request pending", m_tuser, 0);
            end else begin
                want = expected_replies.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[7:0] !== want.slot)
                    report_mismatch("slot_index", m_tdata[7:0], want.slot);
                if (m_tdata[23:8] !== want.found)
                    report_mismatch("found_handle", m_tdata[23:8], want.found);
            end
            taken++;
            if (taken % 40 == 0)
                ready_burst = ($urandom_range(0, 2) == 0);
        end
    end

    initial begin : stimulus
        logic [ACTION_W-1:0] action;
        logic [CODE_W-1:0]   code;
        int unsigned         pick;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].cfg_row) begin
                wait_drained(SETTLE_CYCLES);
                write_table_size(directed_steps[i].size);
            end else begin
                send_request(directed_steps[i].action, directed_steps[i].code,
                             directed_steps[i].handle, directed_steps[i].typed,
                             directed_steps[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained(SETTLE_CYCLES);
            write_table_size(9'(PHASE_SIZES[p]));
            sender_burst = (p == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            // hold the reply side off so the request side backs up
            if (p == HOLD_PHASE)
                hold_off_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                pick = $urandom_range(0, 19);
                code = pick_code();
                if (pick < 8) begin
                    action = ACT_INSERT;
                    live_codes = {live_codes, code};
                    if (live_codes.size() > 40)
                        void'(live_codes.pop_front());
                end else if (pick < 14) begin
                    action = ACT_SEARCH;
                end else if (pick < 19) begin
                    action = ACT_REMOVE;
                end else begin
                    action = ACT_UNKNOWN;
                end
                send_request(action, code, 16'($urandom), PREDICTED, '0);
            end
        end

        wait_drained(TAIL_CYCLES);
        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

[linear_probe_hash_table.f]
+incdir+sv
sv/lpht_pkg.sv
sv/lpht_fifo.sv
sv/lpht_front.sv
sv/lpht_back.sv
sv/linear_probe_hash_table.sv
sim/linear_probe_hash_table_test.sv
